// ===== design/wsf_pkg.sv =====
package wsf_pkg;

   localparam int FRAME_BYTES = 21;
   localparam int IDX_W = 5;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] CHECK_LAST_IDX = IDX_W'(16);

   localparam logic [7:0] START_CODE = 8'h01;
   localparam logic [7:0] FILL_CODE = 8'h30;
   localparam logic [7:0] PRESS_CODE = 8'h3A;
   localparam logic [7:0] CR_CODE = 8'h0D;
   localparam logic [7:0] LF_CODE = 8'h0A;

   typedef struct packed {
      logic dir;
      logic en;
      logic [7:0] mag;
   } wsf_wheel_type;

   typedef struct packed {
      logic press;
      wsf_wheel_type [3:0] slot;
   } wsf_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wsf_q_status_type;

   typedef enum logic [3:0] {
      KIND_START,
      KIND_FLAGS,
      KIND_HIGH,
      KIND_LOW,
      KIND_FILL,
      KIND_PRESS,
      KIND_SUM_HIGH,
      KIND_SUM_LOW,
      KIND_CR,
      KIND_LF
   } wsf_kind_type;

   typedef struct packed {
      wsf_kind_type kind;
      logic [1:0] slot;
   } wsf_decode_type;

   // Byte position to byte kind and wheel slot.
   function automatic wsf_decode_type wsf_decode(input logic [IDX_W-1:0] idx);
      wsf_decode_type d;
      d.slot = 2'd0;
      case (idx)
         5'd0: d.kind = KIND_START;
         5'd1: begin d.kind = KIND_FLAGS; d.slot = 2'd0; end
         5'd2: begin d.kind = KIND_HIGH; d.slot = 2'd0; end
         5'd3: begin d.kind = KIND_LOW; d.slot = 2'd0; end
         5'd4: begin d.kind = KIND_FLAGS; d.slot = 2'd1; end
         5'd5: begin d.kind = KIND_HIGH; d.slot = 2'd1; end
         5'd6: begin d.kind = KIND_LOW; d.slot = 2'd1; end
         5'd7: begin d.kind = KIND_FLAGS; d.slot = 2'd2; end
         5'd8: begin d.kind = KIND_HIGH; d.slot = 2'd2; end
         5'd9: begin d.kind = KIND_LOW; d.slot = 2'd2; end
         5'd10: begin d.kind = KIND_FLAGS; d.slot = 2'd3; end
         5'd11: begin d.kind = KIND_HIGH; d.slot = 2'd3; end
         5'd12: begin d.kind = KIND_LOW; d.slot = 2'd3; end
         5'd14: d.kind = KIND_PRESS;
         5'd17: d.kind = KIND_SUM_HIGH;
         5'd18: d.kind = KIND_SUM_LOW;
         5'd19: d.kind = KIND_CR;
         5'd20: d.kind = KIND_LF;
         default: d.kind = KIND_FILL;
      endcase
      return d;
   endfunction

endpackage

// ===== design/wheel_speed_command_framer.sv =====
// Wheel speed command framer. Pulse start with the four signed wheel speeds
// while busy is low; the block answers with a 21-byte motor command frame,
// one byte per clock on rsp_frame_byte, each beat marked by rsp_valid and the
// final byte (LF) by rsp_last_byte. The receiver cannot stall: every beat is
// present for exactly one cycle. A frame that is already queued follows the
// previous one with no gap. Accepted requests wait in a queue of QUEUE_DEPTH
// frames, so a new request is taken while the previous frame is still going
// out; busy is high only while that queue is full. When the output side is
// idle, the first byte of a frame passes through the queue, the frame
// register and the output register before it appears. The layout register
// (csr_three_wheel_layout) is sampled at request acceptance and should be
// written only while no frame is pending.
module wheel_speed_command_framer import wsf_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [8:0]   req_speed_front_left,
   input  logic signed [8:0]   req_speed_front_right,
   input  logic signed [8:0]   req_speed_back_right,
   input  logic signed [8:0]   req_speed_back_left,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_three_wheel_layout,
   output logic                rsp_valid,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last_byte
);

   wsf_entry_type     front_entry;
   wsf_entry_type     q_head;
   wsf_q_status_type  q_status;
   logic              q_push;
   logic              q_pop;

   assign busy = q_status.full;
   assign q_push = start && !q_status.full;

   wsf_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_three_wheel_layout (csr_three_wheel_layout),
      .speed_front_left       (req_speed_front_left),
      .speed_front_right      (req_speed_front_right),
      .speed_back_right       (req_speed_back_right),
      .speed_back_left        (req_speed_back_left),
      .entry                  (front_entry)
   );

   wsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (front_entry),
      .pop    (q_pop),
      .rdata  (q_head),
      .status (q_status)
   );

   wsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

// ===== design/wsf_front.sv =====
module wsf_front import wsf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_three_wheel_layout,
   input  logic signed [8:0]   speed_front_left,
   input  logic signed [8:0]   speed_front_right,
   input  logic signed [8:0]   speed_back_right,
   input  logic signed [8:0]   speed_back_left,
   output wsf_entry_type       entry
);

   logic layout_ff;
   logic layout_in;

   function automatic wsf_wheel_type to_wheel(input logic [8:0] v);
      wsf_wheel_type w;
      logic [8:0] neg_v;
      neg_v = 9'd0 - v;
      w.en = (v != 9'd0);
      w.dir = v[8];
      if (!v[8]) begin
         w.mag = v[7:0];
      end else if (neg_v[8]) begin
         // most negative code: saturate
         w.mag = 8'hFF;
      end else begin
         w.mag = neg_v[7:0];
      end
      return w;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      layout_in = layout_ff;
      if (csr_valid) begin
         layout_in = csr_three_wheel_layout;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= 1'b0;
      end else begin
         layout_ff <= layout_in;
      end
   end

   // Map wheels to frame slots for the selected layout.
   always_comb begin
      if (layout_ff) begin
         entry.press = 1'b1;
         entry.slot[0] = '0;
         entry.slot[1] = to_wheel(speed_front_left);
         entry.slot[2] = to_wheel(speed_back_right);
         entry.slot[3] = to_wheel(speed_front_right);
      end else begin
         entry.press = 1'b0;
         entry.slot[0] = to_wheel(speed_front_left);
         entry.slot[1] = to_wheel(speed_front_right);
         entry.slot[2] = to_wheel(speed_back_left);
         entry.slot[3] = to_wheel(speed_back_right);
      end
   end

endmodule

// ===== design/wsf_queue.sv =====
module wsf_queue import wsf_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wsf_entry_type     wdata,
   input  logic              pop,
   output wsf_entry_type     rdata,
   output wsf_q_status_type  status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   wsf_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ===== design/wsf_back.sv =====
module wsf_back import wsf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  wsf_q_status_type  q_status,
   input  wsf_entry_type     q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_last_byte
);

   logic              active_ff, active_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   wsf_entry_type     entry_ff, entry_in;
   logic [7:0]        sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_byte_ff, rsp_last_byte_in;
   logic [7:0]        rsp_frame_byte_ff, rsp_frame_byte_in;

   wsf_decode_type    dec;
   wsf_wheel_type     wheel;
   logic [7:0]        byte_val;
   logic              at_last;

   assign at_last = (idx_ff == LAST_IDX);
   assign dec = wsf_decode(idx_ff);
   assign wheel = entry_ff.slot[dec.slot];
   // take the next frame when idle, or as soon as the current one sends its final beat
   assign q_pop = !q_status.empty && (!active_ff || at_last);

   always_comb begin
      case (dec.kind)
         KIND_START: byte_val = START_CODE;
         KIND_FLAGS: byte_val = FILL_CODE | {6'd0, wheel.dir, wheel.en};
         KIND_HIGH: byte_val = FILL_CODE | {4'd0, wheel.mag[7:4]};
         KIND_LOW: byte_val = FILL_CODE | {4'd0, wheel.mag[3:0]};
         KIND_PRESS: byte_val = entry_ff.press ? PRESS_CODE : FILL_CODE;
         KIND_SUM_HIGH: byte_val = FILL_CODE | {4'd0, sum_ff[7:4]};
         KIND_SUM_LOW: byte_val = FILL_CODE | {4'd0, sum_ff[3:0]};
         KIND_CR: byte_val = CR_CODE;
         KIND_LF: byte_val = LF_CODE;
         default: byte_val = FILL_CODE;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      idx_in = idx_ff;
      entry_in = entry_ff;
      sum_in = sum_ff;
      rsp_valid_in = active_ff;
      rsp_last_byte_in = active_ff && at_last;
      rsp_frame_byte_in = byte_val;
      if (active_ff && idx_ff <= CHECK_LAST_IDX) begin
         sum_in = sum_ff ^ byte_val;
      end
      if (q_pop) begin
         active_in = 1'b1;
         idx_in = '0;
         entry_in = q_head;
         sum_in = '0;
      end else if (active_ff && at_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_byte_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_byte_ff <= rsp_last_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      sum_ff <= sum_in;
      rsp_frame_byte_ff <= rsp_frame_byte_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_last_byte_ff |-> rsp_valid_ff)
      else $error("last marker without valid beat");
   assert property (@(posedge clock) disable iff (reset)
      (active_ff && !at_last) |=> (active_ff && idx_ff == $past(idx_ff) + 1'b1))
      else $error("frame broken off mid-way");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (active_ff && idx_ff == '0))
      else $error("new frame did not start at byte zero");

endmodule
